[sv/triangle_area_heron_3d_macros.svh]
// Assertion macros shared by the triangle area block.
`ifndef TRIANGLE_AREA_HERON_3D_MACROS_SVH
`define TRIANGLE_AREA_HERON_3D_MACROS_SVH

// Condition that must hold at every clock edge out of reset.
`define THA_ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) else $error(msg);

// Implication checked in the same cycle.
`define THA_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

[sv/tha_pkg.sv]
// ----------------------------------------------------------------------------
// tha_pkg
// Shared constants for the triangle area block.
// ----------------------------------------------------------------------------
`default_nettype none

package tha_pkg;
  localparam int unsigned COORD_BITS_DEF = 16;
  localparam int unsigned FRAC_BITS_DEF  = 8;
  localparam int unsigned SIDE_W         = 25;
  localparam int unsigned AREA_W         = 41;
endpackage

`default_nettype wire

[sv/tha_sqrt_cell.sv]
// ----------------------------------------------------------------------------
// tha_sqrt_cell
// One bit of a restoring integer square root, registered.
// ----------------------------------------------------------------------------
`default_nettype none

module tha_sqrt_cell #(
  parameter int unsigned N = 8
) (
  input  wire logic           clk_i,
  input  wire logic           en_i,
  input  wire logic [2*N-1:0] rad_i,
  input  wire logic [N+1:0]   rem_i,
  input  wire logic [N-1:0]   root_i,
  output logic      [2*N-1:0] rad_o,
  output logic      [N+1:0]   rem_o,
  output logic      [N-1:0]   root_o
);

  logic [N+3:0] rem_sh;
  logic [N+3:0] trial;
  logic         take;
  logic [N+3:0] rem_new;

  always_comb begin
    rem_sh  = {rem_i, rad_i[2*N-1 -: 2]};
    trial   = {2'b00, root_i, 2'b01};
    take    = (rem_sh >= trial);
    rem_new = take ? (rem_sh - trial) : rem_sh;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rad_o  <= {rad_i[2*N-3:0], 2'b00};
      rem_o  <= rem_new[N+1:0];
      root_o <= {root_i[N-2:0], take};
    end
  end

endmodule

`default_nettype wire

[sv/tha_sqrt_chain.sv]
// ----------------------------------------------------------------------------
// tha_sqrt_chain
// Row of N square root cells; root_o is floor(sqrt(rad)).
// ----------------------------------------------------------------------------
`default_nettype none

module tha_sqrt_chain #(
  parameter int unsigned N = 8
) (
  input  wire logic           clk_i,
  input  wire logic           en_i,
  input  wire logic [2*N-1:0] rad_i,
  output logic      [N-1:0]   root_o
);

  logic [2*N-1:0] rad  [N+1];
  logic [N+1:0]   rem  [N+1];
  logic [N-1:0]   root [N+1];

  assign rad[0]  = rad_i;
  assign rem[0]  = '0;
  assign root[0] = '0;

  for (genvar g = 0; g < N; g++) begin : g_cell
    tha_sqrt_cell #(.N(N)) u_cell (
      .clk_i  (clk_i),
      .en_i   (en_i),
      .rad_i  (rad[g]),
      .rem_i  (rem[g]),
      .root_i (root[g]),
      .rad_o  (rad[g+1]),
      .rem_o  (rem[g+1]),
      .root_o (root[g+1])
    );
  end

  assign root_o = root[N];

endmodule

`default_nettype wire

[sv/triangle_area_heron_3d.sv]
// ----------------------------------------------------------------------------
// triangle_area_heron_3d
// Side lengths and Heron area of a 3-D triangle, fixed point, pipelined.
// ----------------------------------------------------------------------------
// Accepts one triangle per cycle while in_stall_o is low and returns one
// result per triangle, in order. Latency is set by the area square root, a
// row of one-bit cells, preceded by six arithmetic stages (differences,
// squares, sums, products, radicand). The side roots run in shorter rows and
// are delayed to line up. The whole pipeline halts while a result is held by
// out_stall_i.
`default_nettype none

`include "triangle_area_heron_3d_macros.svh"

module triangle_area_heron_3d
  import tha_pkg::*;
#(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF,
  parameter int unsigned FRAC_BITS  = FRAC_BITS_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic signed [COORD_BITS-1:0] a_x_i,
  input  wire logic signed [COORD_BITS-1:0] a_y_i,
  input  wire logic signed [COORD_BITS-1:0] a_z_i,
  input  wire logic signed [COORD_BITS-1:0] b_x_i,
  input  wire logic signed [COORD_BITS-1:0] b_y_i,
  input  wire logic signed [COORD_BITS-1:0] b_z_i,
  input  wire logic signed [COORD_BITS-1:0] c_x_i,
  input  wire logic signed [COORD_BITS-1:0] c_y_i,
  input  wire logic signed [COORD_BITS-1:0] c_z_i,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic [SIDE_W-1:0]                 side_ab_o,
  output logic [SIDE_W-1:0]                 side_ac_o,
  output logic [SIDE_W-1:0]                 side_bc_o,
  output logic [AREA_W-1:0]                 area_o
);

  localparam int unsigned D_W   = COORD_BITS + 1;
  localparam int unsigned SQ_W  = 2 * D_W;
  localparam int unsigned P_W   = SQ_W + 2;
  localparam int unsigned M_W   = P_W + 1;
  localparam int unsigned RAD_W = 2 * M_W;
  localparam int unsigned SN    = (P_W + 2 * FRAC_BITS) / 2;
  localparam int unsigned AN    = (RAD_W + 2 * FRAC_BITS) / 2;
  localparam int unsigned SDLY  = 3 + AN - SN;
  localparam int unsigned LAT   = 6 + AN;

  logic en;
  logic [LAT-1:0] vld_q;

  assign en         = !(vld_q[LAT-1] && out_stall_i);
  assign in_stall_o = !en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAT-2:0], in_valid_i};
    end
  end

  // stage 1: absolute coordinate differences, ab xyz, ac xyz, bc xyz
  logic signed [COORD_BITS-1:0] u [9];
  logic signed [COORD_BITS-1:0] v [9];
  logic signed [D_W-1:0]        diff [9];
  logic [D_W-1:0]               d_d [9];
  logic [D_W-1:0]               d_q [9];

  always_comb begin
    u[0] = a_x_i; u[1] = a_y_i; u[2] = a_z_i;
    u[3] = a_x_i; u[4] = a_y_i; u[5] = a_z_i;
    u[6] = b_x_i; u[7] = b_y_i; u[8] = b_z_i;
    v[0] = b_x_i; v[1] = b_y_i; v[2] = b_z_i;
    v[3] = c_x_i; v[4] = c_y_i; v[5] = c_z_i;
    v[6] = c_x_i; v[7] = c_y_i; v[8] = c_z_i;
    for (int k = 0; k < 9; k++) begin
      diff[k] = D_W'(u[k]) - D_W'(v[k]);
      d_d[k]  = diff[k][D_W-1] ? D_W'(-diff[k]) : D_W'(diff[k]);
    end
  end

  // stage 2: squares
  logic [SQ_W-1:0] sq_q [9];
  // stage 3: squared sides
  logic [P_W-1:0]  p_q, q_q, r_q;
  // stage 4
  logic [2*P_W-1:0] pq_q;
  logic [M_W-1:0]   m_q;
  // stage 5
  logic [RAD_W-1:0] fpq_q, corr_q;
  // stage 6
  logic [RAD_W-1:0] rad_q;

  logic [M_W-1:0] t_sum;
  assign t_sum = M_W'(p_q) + M_W'(q_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 9; k++) begin
        d_q[k]  <= d_d[k];
        sq_q[k] <= d_q[k] * d_q[k];
      end
      p_q    <= P_W'(sq_q[0]) + P_W'(sq_q[1]) + P_W'(sq_q[2]);
      q_q    <= P_W'(sq_q[3]) + P_W'(sq_q[4]) + P_W'(sq_q[5]);
      r_q    <= P_W'(sq_q[6]) + P_W'(sq_q[7]) + P_W'(sq_q[8]);
      pq_q   <= p_q * q_q;
      m_q    <= (t_sum >= M_W'(r_q)) ? (t_sum - M_W'(r_q)) : (M_W'(r_q) - t_sum);
      fpq_q  <= {pq_q, 2'b00};
      corr_q <= m_q * m_q;
      rad_q  <= (corr_q <= fpq_q) ? (fpq_q - corr_q) : '0;
    end
  end

  // square root rows
  logic [SN-1:0] sroot [3];
  logic [AN-1:0] aroot;

  tha_sqrt_chain #(.N(SN)) u_sqrt_ab (
    .clk_i (clk_i), .en_i (en),
    .rad_i ({p_q, {(2*FRAC_BITS){1'b0}}}), .root_o (sroot[0])
  );
  tha_sqrt_chain #(.N(SN)) u_sqrt_ac (
    .clk_i (clk_i), .en_i (en),
    .rad_i ({q_q, {(2*FRAC_BITS){1'b0}}}), .root_o (sroot[1])
  );
  tha_sqrt_chain #(.N(SN)) u_sqrt_bc (
    .clk_i (clk_i), .en_i (en),
    .rad_i ({r_q, {(2*FRAC_BITS){1'b0}}}), .root_o (sroot[2])
  );
  tha_sqrt_chain #(.N(AN)) u_sqrt_area (
    .clk_i (clk_i), .en_i (en),
    .rad_i ({rad_q, {(2*FRAC_BITS){1'b0}}}), .root_o (aroot)
  );

  // side roots finish early; delay them to meet the area root
  logic [SIDE_W-1:0] sd_q [SDLY][3];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        sd_q[0][j] <= SIDE_W'(sroot[j]);
        for (int s = 1; s < SDLY; s++) begin
          sd_q[s][j] <= sd_q[s-1][j];
        end
      end
    end
  end

  logic [AN-3:0] area_full;
  assign area_full = aroot[AN-1:2];

  assign out_valid_o = vld_q[LAT-1];
  assign side_ab_o   = sd_q[SDLY-1][0];
  assign side_ac_o   = sd_q[SDLY-1][1];
  assign side_bc_o   = sd_q[SDLY-1][2];
  assign area_o      = AREA_W'(area_full);

  // floored side ab still meets the triangle inequality within one unit
  `THA_ASSERT_IMPL(a_tri_ineq, out_valid_o,
    ({1'b0, side_ab_o} <= {1'b0, side_ac_o} + {1'b0, side_bc_o} + 1'b1), "side ab too long")
  // a non-zero area needs three distinct vertices
  `THA_ASSERT_IMPL(a_area_sides, out_valid_o && (area_o != '0),
    (side_ab_o != '0) && (side_ac_o != '0) && (side_bc_o != '0), "area without sides")
  // the input side halts exactly when a result is held
  `THA_ASSERT_ALWAYS(a_stall_src, !in_stall_o || out_valid_o, "stall with no result held")

endmodule

`default_nettype wire

[tb/triangle_area_heron_3d_tb.sv]
// ----------------------------------------------------------------------------
// triangle_area_heron_3d_tb
// Self-checking bench: a directed table, then random triangles with bursty
// input and a stalling output, each result checked against the table or a local model.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module triangle_area_heron_3d_tb;
  import tha_pkg::*;

  localparam int unsigned CB = COORD_BITS_DEF;
  localparam int unsigned FB = FRAC_BITS_DEF;
  localparam int LATENCY = 51;
  localparam int N_RANDOM = 1630;

  typedef logic signed [CB-1:0] coord_t;

  typedef struct packed {
    coord_t ax, ay, az, bx, by, bz, cx, cy, cz;
  } tri_t;

  typedef struct packed {
    logic [SIDE_W-1:0] ab, ac, bc;
    logic [AREA_W-1:0] area;
  } geom_t;

  typedef struct {
    tri_t  t;
    bit    known;
    geom_t g;
  } row_t;

  logic clk_i, rst_ni;
  logic in_valid_i, in_stall_o, out_valid_o, out_stall_i;
  coord_t a_x_i, a_y_i, a_z_i, b_x_i, b_y_i, b_z_i, c_x_i, c_y_i, c_z_i;
  logic [SIDE_W-1:0] side_ab_o, side_ac_o, side_bc_o;
  logic [AREA_W-1:0] area_o;

  geom_t geom_q[$];
  int    n_errors = 0;
  bit    hold_off = 0;
  bit    send_done = 0;

  triangle_area_heron_3d uut (.*);

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #20_000_000;
    $display("FAIL triangle_area_heron_3d");
    $finish;
  end

  function automatic logic [127:0] isqrt(logic [255:0] x);
    logic [127:0] root;
    logic [127:0] cand;
    root = '0;
    for (int i = 127; i >= 0; i--) begin
      cand = root | (128'd1 << i);
      if ({128'd0, cand} * {128'd0, cand} <= x) root = cand;
    end
    return root;
  endfunction

  function automatic logic [63:0] dist_sq(coord_t u0, u1, u2, coord_t v0, v1, v2);
    longint d0, d1, d2;
    d0 = longint'(u0) - longint'(v0);
    d1 = longint'(u1) - longint'(v1);
    d2 = longint'(u2) - longint'(v2);
    return d0 * d0 + d1 * d1 + d2 * d2;
  endfunction

  function automatic geom_t heron_geom(tri_t t);
    logic [63:0] p, q, r, m;
    logic [255:0] four_pq, corr, rad;
    logic [127:0] aroot;
    geom_t g;
    p = dist_sq(t.ax, t.ay, t.az, t.bx, t.by, t.bz);
    q = dist_sq(t.ax, t.ay, t.az, t.cx, t.cy, t.cz);
    r = dist_sq(t.bx, t.by, t.bz, t.cx, t.cy, t.cz);
    g.ab = SIDE_W'(isqrt(256'(p) << (2 * FB)));
    g.ac = SIDE_W'(isqrt(256'(q) << (2 * FB)));
    g.bc = SIDE_W'(isqrt(256'(r) << (2 * FB)));
    m = (p + q >= r) ? p + q - r : r - p - q;
    four_pq = (256'(p) * 256'(q)) << 2;
    corr = 256'(m) * 256'(m);
    rad = (corr <= four_pq) ? four_pq - corr : '0;
    aroot = isqrt(rad << (2 * FB)) >> 2;
    g.area = AREA_W'(aroot);
    return g;
  endfunction

  function automatic coord_t rnd_coord(int spread);
    case (spread)
      0: return coord_t'($urandom);
      1: return coord_t'($urandom_range(0, 40) - 20);
      default: return $urandom_range(0, 1) ? coord_t'(16'h8000) : coord_t'(16'h7fff);
    endcase
  endfunction

  function automatic tri_t rnd_tri();
    tri_t t;
    int s, k;
    s = $urandom_range(0, 9) < 7 ? 0 : $urandom_range(1, 2);
    t = {rnd_coord(s), rnd_coord(s), rnd_coord(s), rnd_coord(s), rnd_coord(s),
         rnd_coord(s), rnd_coord(s), rnd_coord(s), rnd_coord(s)};
    // collinear or coincident vertices now and then
    if ($urandom_range(0, 9) == 0) begin
      k = int'($urandom_range(0, 4)) - 2;
      t.cx = t.ax + coord_t'(k * (t.bx - t.ax));
      t.cy = t.ay + coord_t'(k * (t.by - t.ay));
      t.cz = t.az + coord_t'(k * (t.bz - t.az));
    end
    return t;
  endfunction

  task automatic offer(tri_t t, bit known, geom_t g);
    a_x_i <= t.ax; a_y_i <= t.ay; a_z_i <= t.az;
    b_x_i <= t.bx; b_y_i <= t.by; b_z_i <= t.bz;
    c_x_i <= t.cx; c_y_i <= t.cy; c_z_i <= t.cz;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    geom_q.push_back(known ? g : heron_geom(t));
  endtask

  task automatic idle_gap();
    int gap;
    gap = $urandom_range(0, 3) == 0 ? $urandom_range(1, 6) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Stimulus
  initial begin
    localparam coord_t MX = 16'sh7fff;
    localparam coord_t MN = -16'sh8000;
    row_t dir[$];
    int burst;
    in_valid_i = 0;
    {a_x_i, a_y_i, a_z_i, b_x_i, b_y_i, b_z_i, c_x_i, c_y_i, c_z_i} = '0;
    rst_ni = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    dir.push_back('{'{default: 0}, 1, '{0, 0, 0, 0}});
    // 3-4-5 right triangle: area 6
    dir.push_back('{'{0, 0, 0, 3, 0, 0, 0, 4, 0}, 1, '{768, 1024, 1280, 1536}});
    dir.push_back('{'{0, 0, 0, 1, 0, 0, 0, 1, 0}, 1, '{256, 256, 362, 128}});
    // collinear
    dir.push_back('{'{0, 0, 0, 1, 1, 1, 2, 2, 2}, 1, '{443, 886, 443, 0}});
    dir.push_back('{'{MN, MN, MN, MX, MX, MX, MN, MN, MN}, 0, '0});
    dir.push_back('{'{MN, MN, MN, MX, MN, MN, MN, MX, MN}, 0, '0});
    dir.push_back('{'{MX, MN, MN, MN, MX, MN, MN, MN, MX}, 0, '0});
    dir.push_back('{'{MN, MN, MN, MX, MX, MN, MN, MX, MX}, 0, '0});
    dir.push_back('{'{MX, MX, MX, MX, MX, MX, MX, MX, MX}, 1, '{0, 0, 0, 0}});
    dir.push_back('{'{-1, -1, -1, 0, 0, 0, 1, 1, 1}, 0, '0});
    dir.push_back('{'{5, 5, 5, 5, 5, 5, -7, 3, 9}, 0, '0});
    dir.push_back('{'{16'sh5555, 16'sh2aaa, -16'sh5556, -16'sh2aab, 1, -2,
                      16'sh0f0f, -16'sh0f10, 16'sh7f00}, 0, '0});
    foreach (dir[i]) offer(dir[i].t, dir[i].known, dir[i].g);

    for (int n = 0; n < N_RANDOM; ) begin
      burst = $urandom_range(1, 40);
      for (int b = 0; b < burst && n < N_RANDOM; b++, n++) begin
        if (n == 400) hold_off <= 1;
        offer(rnd_tri(), 0, '0);
      end
      idle_gap();
      if (n >= 900 && n < 940) begin
        // drain completely before going on
        in_valid_i <= 1'b0;
        while (geom_q.size() != 0) @(posedge clk_i);
      end
    end
    in_valid_i <= 1'b0;
    send_done = 1;
  end

  // Output stall pattern, plus one long hold-off
  initial begin
    int stretch;
    out_stall_i = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_off) begin
        out_stall_i <= 1;
        stretch = 0;
        while (stretch < 200) begin
          @(posedge clk_i);
          stretch++;
        end
        hold_off = 0;
        out_stall_i <= 0;
      end else if ($urandom_range(0, 7) == 0) begin
        out_stall_i <= 1;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
        out_stall_i <= 0;
        repeat ($urandom_range(0, 60)) @(posedge clk_i);
      end
    end
  end

  // Result checker
  always @(posedge clk_i) begin
    geom_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (geom_q.size() == 0) begin
        $display("%0t: unexpected result ab=%0d ac=%0d bc=%0d area=%0d", $time,
                 side_ab_o, side_ac_o, side_bc_o, area_o);
        n_errors++;
      end else begin
        e = geom_q.pop_front();
        if (side_ab_o !== e.ab) begin
          $display("%0t: side_ab expected %0d got %0d", $time, e.ab, side_ab_o);
          n_errors++;
        end
        if (side_ac_o !== e.ac) begin
          $display("%0t: side_ac expected %0d got %0d", $time, e.ac, side_ac_o);
          n_errors++;
        end
        if (side_bc_o !== e.bc) begin
          $display("%0t: side_bc expected %0d got %0d", $time, e.bc, side_bc_o);
          n_errors++;
        end
        if (area_o !== e.area) begin
          $display("%0t: area expected %0d got %0d", $time, e.area, area_o);
          n_errors++;
        end
      end
    end
  end

  initial begin
    wait (send_done);
    while (geom_q.size() != 0) @(posedge clk_i);
    repeat (2 * LATENCY) @(posedge clk_i);
    if (n_errors == 0 && geom_q.size() == 0) $display("PASS triangle_area_heron_3d");
    else $display("FAIL triangle_area_heron_3d");
    $finish;
  end

endmodule

`default_nettype wire
